// ----- src/lru_write_back_chunk_cache_unit_defines.svh -----
// ----------------------------------------------------------------------------
// lru write-back chunk cache: assertion macros
// concurrent checks clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LRU_WRITE_BACK_CHUNK_CACHE_UNIT_DEFINES_SVH
`define LRU_WRITE_BACK_CHUNK_CACHE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LWBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LWBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lwbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lwbc_pkg
// shared widths, request modes and event codes of the chunk cache directory
// ----------------------------------------------------------------------------
package lwbc_pkg;

    localparam int MODE_W   = 2;
    localparam int CHUNK_W  = 32;
    localparam int WORDS_W  = 24;
    localparam int BUDGET_W = 40;
    localparam int EVENT_W  = 3;
    localparam int USED_W   = 32;
    localparam int DCNT_W   = 6;

    localparam logic [BUDGET_W-1:0] MIN_BUDGET = 40'd2147483648;

    localparam logic [MODE_W-1:0] MODE_READ      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH_ONE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH_ALL = 2'd3;

    localparam logic [EVENT_W-1:0] EV_HIT         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_MISS_FILL   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_EVICT_CLEAN = 3'd2;
    localparam logic [EVENT_W-1:0] EV_EVICT_WB    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FLUSH_WB    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_NOTHING     = 3'd5;
    localparam logic [EVENT_W-1:0] EV_FLUSH_DONE  = 3'd6;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [CHUNK_W-1:0]  chunk_t;
    typedef logic [WORDS_W-1:0]  words_t;
    typedef logic [BUDGET_W-1:0] budget_t;
    typedef logic [EVENT_W-1:0]  event_t;
    typedef logic [USED_W-1:0]   used_t;
    typedef logic [DCNT_W-1:0]   dcnt_t;

endpackage

// ----- src/lwbc_ifs.sv -----
// ----------------------------------------------------------------------------
// lwbc channel interfaces
// valid/ready channels for configuration, requests and results
// ----------------------------------------------------------------------------
interface lwbc_cfg_if;
    logic                 valid;
    logic                 ready;
    lwbc_pkg::budget_t    budget_bytes;
    modport source (output valid, output budget_bytes, input ready);
    modport sink   (input valid, input budget_bytes, output ready);
endinterface

interface lwbc_req_if;
    logic                 valid;
    logic                 ready;
    lwbc_pkg::mode_t      mode;
    lwbc_pkg::chunk_t     chunk_index;
    lwbc_pkg::words_t     chunk_words;
    modport source (output valid, output mode, output chunk_index, output chunk_words,
                    input ready);
    modport sink   (input valid, input mode, input chunk_index, input chunk_words,
                    output ready);
endinterface

interface lwbc_res_if;
    logic                 valid;
    logic                 ready;
    lwbc_pkg::event_t     event_res;
    lwbc_pkg::chunk_t     event_chunk;
    logic                 last;
    lwbc_pkg::used_t      bytes_used;
    lwbc_pkg::dcnt_t      dirty_entries;
    modport source (output valid, output event_res, output event_chunk, output last,
                    output bytes_used, output dirty_entries, input ready);
    modport sink   (input valid, input event_res, input event_chunk, input last,
                    input bytes_used, input dirty_entries, output ready);
endinterface

// ----- src/lru_write_back_chunk_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_write_back_chunk_cache_unit
// fully associative lru write-back chunk cache directory with a byte budget
// ----------------------------------------------------------------------------
// channel  role    payload                                            accepted
// cfg      sink    budget_bytes                                       valid & ready
// req      sink    mode, chunk_index, chunk_words                     valid & ready
// res      source  event_res, event_chunk, last, bytes_used,          valid & ready
//                  dirty_entries
//
// one request at a time; req.ready is high only while the sequencer is idle
// tag lookup walks the slots through one ram read port, a read state and then a
// compare state per slot, and stops at a hit; flush-all walks every slot the same way
// each eviction costs an lru scan plus the ram read, the eviction and a new budget
// check; a fill adds a free-slot scan plus the budget check and the fill
// the single output register stalls the sequencer while res is not taken
// reset clears valid and dirty bits and counters at once; no clearing pass
// ----------------------------------------------------------------------------
`include "lru_write_back_chunk_cache_unit_defines.svh"

module lru_write_back_chunk_cache_unit #(
    parameter int SLOTS      = 32,
    parameter int INDEX_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lwbc_cfg_if.sink    cfg,
    lwbc_req_if.sink    req,
    lwbc_res_if.source  res
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int REC_W  = IDX_W;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TAG_W  = INDEX_BITS;
    localparam int WRD_W  = lwbc_pkg::WORDS_W;
    localparam int RAM_W  = TAG_W + WRD_W;
    localparam int SUM_W  = lwbc_pkg::BUDGET_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_HRD     = 4'd1;
    localparam logic [3:0] S_HEX     = 4'd2;
    localparam logic [3:0] S_RESOLVE = 4'd3;
    localparam logic [3:0] S_CHECK   = 4'd4;
    localparam logic [3:0] S_LSCAN   = 4'd5;
    localparam logic [3:0] S_VRD     = 4'd6;
    localparam logic [3:0] S_VEX     = 4'd7;
    localparam logic [3:0] S_FSCAN   = 4'd8;
    localparam logic [3:0] S_FILL    = 4'd9;
    localparam logic [3:0] S_FARD    = 4'd10;
    localparam logic [3:0] S_FAEX    = 4'd11;
    localparam logic [3:0] S_FADONE  = 4'd12;

    logic [3:0]              state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    lwbc_pkg::mode_t         mode_reg, mode_next;
    lwbc_pkg::chunk_t        chunk_reg, chunk_next;
    logic [TAG_W-1:0]        tag_reg, tag_next;
    lwbc_pkg::words_t        words_reg, words_next;
    logic                    hit_reg, hit_next;
    logic [SLOTS-1:0]        valid_reg, valid_next;
    logic [SLOTS-1:0]        dirty_reg, dirty_next;
    logic [REC_W-1:0]        rec_reg [SLOTS];
    logic [REC_W-1:0]        rec_next [SLOTS];
    logic [CNT_W-1:0]        nvalid_reg, nvalid_next;
    logic [CNT_W-1:0]        dcnt_reg, dcnt_next;
    lwbc_pkg::used_t         used_reg, used_next;
    lwbc_pkg::budget_t       budget_reg;

    logic                    res_vld_reg;
    lwbc_pkg::event_t        ev_reg;
    lwbc_pkg::chunk_t        evchunk_reg;
    logic                    last_reg;
    lwbc_pkg::used_t         bytes_reg;
    lwbc_pkg::dcnt_t         dout_reg;

    // emit request from the sequencer
    logic                    emit;
    lwbc_pkg::event_t        emit_ev;
    lwbc_pkg::chunk_t        emit_chunk;
    logic                    emit_last;
    logic                    can_emit;

    // directory ram: tag and word count per slot
    logic                    ram_we;
    logic [RAM_W-1:0]        ram_wdata;
    logic [RAM_W-1:0]        ram_rdata;
    logic [TAG_W-1:0]        rd_tag;
    lwbc_pkg::words_t        rd_words;
    lwbc_pkg::chunk_t        rd_chunk;

    logic [TAG_W+31:0]       req_ext;
    logic [TAG_W+31:0]       tag_ext;
    lwbc_pkg::budget_t       budget_eff;
    logic [SUM_W-1:0]        need_sum;
    logic                    evict_need;
    logic [REC_W-1:0]        lru_rec;
    logic [REC_W-1:0]        cur_rec;

    lwbc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_dir_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_tag    = ram_rdata[RAM_W-1:WRD_W];
    assign rd_words  = ram_rdata[WRD_W-1:0];
    assign ram_wdata = {tag_reg, words_reg};

    // tag is the low INDEX_BITS bits of the chunk index, zero-extended back
    assign req_ext  = {{TAG_W{1'b0}}, req.chunk_index};
    assign tag_ext  = {32'd0, rd_tag};
    assign rd_chunk = tag_ext[31:0];

    assign budget_eff = (budget_reg < lwbc_pkg::MIN_BUDGET) ? lwbc_pkg::MIN_BUDGET
                                                            : budget_reg;
    assign need_sum   = SUM_W'(used_reg) + SUM_W'({words_reg, 2'b00});
    assign evict_need = (nvalid_reg != '0)
                        && ((need_sum > SUM_W'(budget_eff)) || (nvalid_reg == FULL_CNT));
    assign lru_rec    = REC_W'(nvalid_reg - CNT_W'(1));
    assign cur_rec    = rec_reg[idx_reg];

    assign can_emit  = !res_vld_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        mode_next   = mode_reg;
        chunk_next  = chunk_reg;
        tag_next    = tag_reg;
        words_next  = words_reg;
        hit_next    = hit_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        rec_next    = rec_reg;
        nvalid_next = nvalid_reg;
        dcnt_next   = dcnt_reg;
        used_next   = used_reg;
        ram_we      = 1'b0;
        emit        = 1'b0;
        emit_ev     = lwbc_pkg::EV_HIT;
        emit_chunk  = chunk_reg;
        emit_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    chunk_next = req.chunk_index;
                    tag_next   = req_ext[TAG_W-1:0];
                    words_next = req.chunk_words;
                    hit_next   = 1'b0;
                    idx_next   = '0;
                    state_next = (req.mode == lwbc_pkg::MODE_FLUSH_ALL) ? S_FARD : S_HRD;
                end
            end
            S_HRD:
            begin
                state_next = S_HEX;
            end
            S_HEX:
            begin
                // idx stays on the hit slot
                if (valid_reg[idx_reg] && (rd_tag == tag_reg))
                begin
                    hit_next   = 1'b1;
                    state_next = S_RESOLVE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_HRD;
                end
            end
            S_RESOLVE:
            begin
                if (mode_reg == lwbc_pkg::MODE_FLUSH_ONE)
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (hit_reg && dirty_reg[idx_reg])
                        begin
                            dirty_next[idx_reg] = 1'b0;
                            dcnt_next           = dcnt_reg - CNT_W'(1);
                            emit_ev             = lwbc_pkg::EV_FLUSH_WB;
                        end
                        else
                        begin
                            emit_ev = lwbc_pkg::EV_NOTHING;
                        end
                    end
                end
                else if (hit_reg)
                begin
                    if (can_emit)
                    begin
                        // touch: younger entries age by one, hit becomes mru
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (valid_reg[i] && (rec_reg[i] < cur_rec))
                            begin
                                rec_next[i] = rec_reg[i] + REC_W'(1);
                            end
                        end
                        rec_next[idx_reg] = '0;
                        if ((mode_reg == lwbc_pkg::MODE_WRITE) && !dirty_reg[idx_reg])
                        begin
                            dirty_next[idx_reg] = 1'b1;
                            dcnt_next           = dcnt_reg + CNT_W'(1);
                        end
                        emit       = 1'b1;
                        emit_ev    = lwbc_pkg::EV_HIT;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                idx_next   = '0;
                state_next = evict_need ? S_LSCAN : S_FSCAN;
            end
            S_LSCAN:
            begin
                // ages are kept dense, so the lru entry holds age nvalid-1
                if (valid_reg[idx_reg] && (cur_rec == lru_rec))
                begin
                    state_next = S_VRD;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_VRD:
            begin
                state_next = S_VEX;
            end
            S_VEX:
            begin
                if (can_emit)
                begin
                    used_next           = used_reg - lwbc_pkg::USED_W'({rd_words, 2'b00});
                    valid_next[idx_reg] = 1'b0;
                    nvalid_next         = nvalid_reg - CNT_W'(1);
                    emit                = 1'b1;
                    emit_chunk          = rd_chunk;
                    emit_last           = 1'b0;
                    if (dirty_reg[idx_reg])
                    begin
                        dirty_next[idx_reg] = 1'b0;
                        dcnt_next           = dcnt_reg - CNT_W'(1);
                        emit_ev             = lwbc_pkg::EV_EVICT_WB;
                    end
                    else
                    begin
                        emit_ev = lwbc_pkg::EV_EVICT_CLEAN;
                    end
                    state_next = S_CHECK;
                end
            end
            S_FSCAN:
            begin
                if (!valid_reg[idx_reg])
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_FILL:
            begin
                if (can_emit)
                begin
                    ram_we = 1'b1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            rec_next[i] = rec_reg[i] + REC_W'(1);
                        end
                    end
                    rec_next[idx_reg]   = '0;
                    valid_next[idx_reg] = 1'b1;
                    nvalid_next         = nvalid_reg + CNT_W'(1);
                    if (mode_reg == lwbc_pkg::MODE_WRITE)
                    begin
                        dirty_next[idx_reg] = 1'b1;
                        dcnt_next           = dcnt_reg + CNT_W'(1);
                    end
                    used_next  = used_reg + lwbc_pkg::USED_W'({words_reg, 2'b00});
                    emit       = 1'b1;
                    emit_ev    = lwbc_pkg::EV_MISS_FILL;
                    state_next = S_IDLE;
                end
            end
            S_FARD:
            begin
                state_next = S_FAEX;
            end
            S_FAEX:
            begin
                if (valid_reg[idx_reg] && dirty_reg[idx_reg])
                begin
                    if (can_emit)
                    begin
                        dirty_next[idx_reg] = 1'b0;
                        dcnt_next           = dcnt_reg - CNT_W'(1);
                        emit                = 1'b1;
                        emit_ev             = lwbc_pkg::EV_FLUSH_WB;
                        emit_chunk          = rd_chunk;
                        emit_last           = 1'b0;
                        idx_next            = idx_reg + IDX_W'(1);
                        state_next          = (idx_reg == LAST_IDX) ? S_FADONE : S_FARD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = (idx_reg == LAST_IDX) ? S_FADONE : S_FARD;
                end
            end
            S_FADONE:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_ev    = lwbc_pkg::EV_FLUSH_DONE;
                    emit_chunk = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            dirty_reg   <= '0;
            nvalid_reg  <= '0;
            dcnt_reg    <= '0;
            used_reg    <= '0;
            budget_reg  <= lwbc_pkg::MIN_BUDGET;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            nvalid_reg <= nvalid_next;
            dcnt_reg   <= dcnt_next;
            used_reg   <= used_next;
            if (cfg.valid)
            begin
                budget_reg <= cfg.budget_bytes;
            end
            if (emit)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // payload and datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        mode_reg  <= mode_next;
        chunk_reg <= chunk_next;
        tag_reg   <= tag_next;
        words_reg <= words_next;
        hit_reg   <= hit_next;
        rec_reg   <= rec_next;
        if (emit)
        begin
            ev_reg      <= emit_ev;
            evchunk_reg <= emit_chunk;
            last_reg    <= emit_last;
            bytes_reg   <= used_next;
            dout_reg    <= lwbc_pkg::DCNT_W'(dcnt_next);
        end
    end

    assign res.valid         = res_vld_reg;
    assign res.event_res     = ev_reg;
    assign res.event_chunk   = evchunk_reg;
    assign res.last          = last_reg;
    assign res.bytes_used    = bytes_reg;
    assign res.dirty_entries = dout_reg;

    // checks
    `LWBC_ASSERT_NOW(a_dirty_le_valid, 1'b1, dcnt_reg <= nvalid_reg,
        "dirty count exceeds valid count")
    `LWBC_ASSERT_NOW(a_valid_le_slots, 1'b1, nvalid_reg <= FULL_CNT,
        "valid count exceeds slot count")
    `LWBC_ASSERT_NEXT(a_last_to_idle, emit && emit_last, state_reg == S_IDLE,
        "sequencer not idle after final result")

endmodule

// ----- src/lwbc_ram.sv -----
// ----------------------------------------------------------------------------
// lwbc_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module lwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
